### rtl/aes128_pkg.sv
// AES-128 package: S-box, GF(2^8) helpers, round and key-schedule functions.
// Used by the round unit, key unit and top level.
`timescale 1ns / 1ps
`default_nettype none
package aes128_pkg;

  localparam int unsigned NumRounds = 10;
  localparam int unsigned RndW      = 4;

  typedef enum logic [0:0] {
    CFG_KEY_HIGH = 1'b0,
    CFG_KEY_LOW  = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic             load;   // initial key addition, restart schedule
    logic             step;   // one round
    logic             last;   // final round, no MixColumns
    logic [RndW-1:0]  rnd;    // round number 1..10
  } round_ctl_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] r;
    case (a)
      8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
      8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
      8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
      8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
      8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
      8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
      8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
      8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
      8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
      8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
      8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
      8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
      8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
      8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
      8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
      8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
      8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
      8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
      8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
      8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
      8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
      8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
      8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
      8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
      8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
      8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
      8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
      8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
      8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
      8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
      8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
      8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
      8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
      8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
      8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
      8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
      8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
      8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
      8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
      8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
      8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
      8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
      8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
      8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
      8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
      8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
      8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
      8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
      8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
      8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
      8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
      8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
      8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
      8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
      8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
      8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
      8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
      8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
      8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
      8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
      8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
      8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
      8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
      8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] gf_dbl(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  // byte i of a 128-bit word, byte 0 in bits 127:120
  function automatic logic [7:0] byte_at(input logic [127:0] w, input int i);
    return w[127-8*i -: 8];
  endfunction

  // round constant for round 1..10
  function automatic logic [7:0] rcon(input logic [RndW-1:0] r);
    logic [7:0] c;
    case (r)
      4'd1: c = 8'h01; 4'd2: c = 8'h02; 4'd3: c = 8'h04; 4'd4: c = 8'h08;
      4'd5: c = 8'h10; 4'd6: c = 8'h20; 4'd7: c = 8'h40; 4'd8: c = 8'h80;
      4'd9: c = 8'h1b; 4'd10: c = 8'h36;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

### rtl/aes128_key_unit.sv
// AES-128 key schedule: derives the next round key from the current one each round.
// Depends on aes128_pkg.
`timescale 1ns / 1ps
`default_nettype none
module aes128_key_unit (
  input  wire logic                   clk,
  input  wire aes128_pkg::round_ctl_t ctl,
  input  wire logic [127:0]           key,
  output      logic [127:0]           rkey_nxt,  // key for the round being run now
  output      logic [127:0]           rkey       // key of the last round run
);
  import aes128_pkg::*;

  logic [127:0] rkey_r;
  logic [31:0]  w0, w1, w2, w3, t;

  always_comb begin
    w0 = rkey_r[127:96];
    w1 = rkey_r[95:64];
    w2 = rkey_r[63:32];
    w3 = rkey_r[31:0];
    t  = {sbox(w3[23:16]) ^ rcon(ctl.rnd), sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
    rkey_nxt[127:96] = w0 ^ t;
    rkey_nxt[95:64]  = w0 ^ t ^ w1;
    rkey_nxt[63:32]  = w0 ^ t ^ w1 ^ w2;
    rkey_nxt[31:0]   = w0 ^ t ^ w1 ^ w2 ^ w3;
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      rkey_r <= key;
    end else if (ctl.step) begin
      rkey_r <= rkey_nxt;
    end
  end

  assign rkey = rkey_r;

endmodule
`default_nettype wire

### rtl/aes128_round_unit.sv
// AES-128 shared round datapath: SubBytes, ShiftRows, MixColumns, AddRoundKey.
// Depends on aes128_pkg.
`timescale 1ns / 1ps
`default_nettype none
module aes128_round_unit (
  input  wire logic                   clk,
  input  wire aes128_pkg::round_ctl_t ctl,
  input  wire logic [127:0]           din,
  input  wire logic [127:0]           key,
  input  wire logic [127:0]           rkey,
  output      logic [127:0]           state
);
  import aes128_pkg::*;

  logic [127:0] state_r;
  logic [127:0] ss;
  logic [127:0] mc;
  logic [127:0] state_nxt;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        ss[127-8*(r+4*c) -: 8] = sbox(byte_at(state_r, r + 4*((c + r) % 4)));
      end
    end
    for (int c = 0; c < 4; c++) begin
      logic [7:0] a0, a1, a2, a3, al;
      a0 = byte_at(ss, 4*c);
      a1 = byte_at(ss, 4*c+1);
      a2 = byte_at(ss, 4*c+2);
      a3 = byte_at(ss, 4*c+3);
      al = a0 ^ a1 ^ a2 ^ a3;
      mc[127-32*c -: 32] = {a0 ^ al ^ gf_dbl(a0 ^ a1), a1 ^ al ^ gf_dbl(a1 ^ a2),
                            a2 ^ al ^ gf_dbl(a2 ^ a3), a3 ^ al ^ gf_dbl(a3 ^ a0)};
    end
    state_nxt = (ctl.last ? ss : mc) ^ rkey;
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      state_r <= din ^ key;
    end else if (ctl.step) begin
      state_r <= state_nxt;
    end
  end

  assign state = state_r;

endmodule
`default_nettype wire

### rtl/aes128_block_encrypt_core.sv
// AES-128 encryption core top level: key registers, round sequencer, output hold.
// Depends on aes128_pkg, aes128_key_unit and aes128_round_unit.
`timescale 1ns / 1ps
`default_nettype none
// channel | dir | tdata fields (low bit first)
// in_     | in  | block_high[63:0], block_low[127:64]
// out_    | out | cipher_high[63:0], cipher_low[127:64]
// cfg_    | in  | cfg_index: 0 key_high, 1 key_low; other indexes ignored
// Each item runs through the shared round unit as key add + 10 rounds, the result
// valid in ST_OUT; one item at a time, set by the single round unit.
// in_tready is low while an item runs or its result is not yet taken.
// Round keys are derived on the fly, one per cycle, by the key unit.
// rst_n is synchronous; it clears the keys and control state.
module aes128_block_encrypt_core (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output      logic         in_tready,
  input  wire logic [127:0] in_tdata,   // block_high, block_low
  output      logic         out_tvalid,
  input  wire logic         out_tready,
  output      logic [127:0] out_tdata,  // cipher_high, cipher_low
  input  wire logic         cfg_valid,
  output      logic         cfg_ready,
  input  wire logic [0:0]   cfg_index,
  input  wire logic [63:0]  cfg_data
);
  import aes128_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_OUT} state_t;

  state_t          st_r, st_nxt;
  logic [RndW-1:0] rnd_r, rnd_nxt;
  logic [63:0]     key_high_r, key_low_r;
  round_ctl_t      ctl;
  logic [127:0]    key, rkey_nxt, rkey, state;
  logic            in_acc;

  assign key       = {key_high_r, key_low_r};
  assign in_tready = (st_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign out_tvalid = (st_r == ST_OUT);
  assign out_tdata  = {state[63:0], state[127:64]};

  always_comb begin
    ctl.load = in_acc;
    ctl.step = (st_r == ST_RUN);
    ctl.last = (rnd_r == RndW'(NumRounds));
    ctl.rnd  = rnd_r;
    st_nxt   = st_r;
    rnd_nxt  = rnd_r;
    case (st_r)
      ST_IDLE: begin
        if (in_acc) begin
          st_nxt  = ST_RUN;
          rnd_nxt = RndW'(1);
        end
      end
      ST_RUN: begin
        rnd_nxt = rnd_r + RndW'(1);
        if (ctl.last) st_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_tready) st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= ST_IDLE;
      rnd_r      <= '0;
      key_high_r <= '0;
      key_low_r  <= '0;
    end else begin
      st_r  <= st_nxt;
      rnd_r <= rnd_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_KEY_HIGH: key_high_r <= cfg_data;
          CFG_KEY_LOW:  key_low_r  <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  aes128_key_unit u_key (
    .clk      (clk),
    .ctl      (ctl),
    .key      (key),
    .rkey_nxt (rkey_nxt),
    .rkey     (rkey)
  );

  aes128_round_unit u_round (
    .clk   (clk),
    .ctl   (ctl),
    .din   ({in_tdata[63:0], in_tdata[127:64]}),
    .key   (key),
    .rkey  (rkey_nxt),
    .state (state)
  );

  a_rnd_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_RUN |-> rnd_r >= RndW'(1) && rnd_r <= RndW'(NumRounds)) else $error("round");
  a_run_len: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_RUN && ctl.last |=> st_r == ST_OUT) else $error("run end");
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> st_r == ST_RUN && rnd_r == RndW'(1)) else $error("start");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && rkey == $past(rkey)) else $error("hold");

endmodule
`default_nettype wire
